@@ src/data_run_list_decoder_macros.svh @@
// assertion helpers for the run list decoder
`ifndef DATA_RUN_LIST_DECODER_MACROS_SVH
`define DATA_RUN_LIST_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("run list decoder check failed");

// next-cycle implication, checked out of reset
`define DRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("run list decoder check failed");

`endif

@@ src/drl_pkg.sv @@
package drl_pkg;

  localparam int DRL_MAX_FIELD_BYTES = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0,
    KIND_END = 2'd1,
    KIND_BAD = 2'd2
  } kind_t;

  // one result from the decode logic
  typedef struct packed {
    logic               emit;
    kind_t              kind;
    logic        [63:0] run_length;
    logic signed [63:0] run_start;
  } res_t;

endpackage

@@ src/drl_in_stage.sv @@
module drl_in_stage import drl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_run_byte,
  input  logic       adv,
  output logic       in_stall,
  output logic       valid_r,
  output logic [7:0] byte_r
);

  logic valid_nxt;

  // holding an item that the decode stage cannot take yet
  assign in_stall  = valid_r && !adv;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_run_byte;
    end
  end

endmodule

@@ src/drl_core.sv @@
module drl_core import drl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = DRL_MAX_FIELD_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] run_byte,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  left_r, left_nxt, left_dec;
  logic [3:0]  osz_r, osz_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] delta_r, delta_nxt;
  logic [63:0] prev_r, prev_nxt;
  logic [63:0] part;
  logic [63:0] ext_mask;
  logic [63:0] fin_delta;
  logic [63:0] fin_start;
  logic [3:0]  hdr_osz, hdr_lsz;

  assign part     = 64'(run_byte) << {pos_r, 3'b000};
  assign hdr_osz  = run_byte[7:4];
  assign hdr_lsz  = run_byte[3:0];
  assign left_dec = left_r - {3'd0, (left_r != 4'd0)};

  // sign extension from the last offset byte, full eight bytes taken as is
  assign ext_mask = (osz_r < 4'd8 && run_byte[7]) ? (~64'd0 << {osz_r[2:0], 3'b000})
                                                  : 64'd0;
  // a run ends in the length phase only when it is sparse: delta zero
  assign fin_delta = (phase_r == PH_OFFSET) ? ((delta_r | part) | ext_mask) : 64'd0;
  assign fin_start = prev_r + fin_delta;

  always_comb begin
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    osz_nxt        = osz_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    delta_nxt      = delta_r;
    prev_nxt       = prev_r;
    res.emit       = 1'b0;
    res.kind       = KIND_RUN;
    res.run_length = 64'd0;
    res.run_start  = 64'sd0;
    if (step) begin
      case (phase_r)
        PH_LENGTH, PH_OFFSET: begin
          if (phase_r == PH_LENGTH) begin
            len_nxt = len_r | part;
          end else begin
            delta_nxt = delta_r | part;
          end
          pos_nxt  = pos_r + 3'd1;
          left_nxt = left_dec;
          if (left_dec == 4'd0) begin
            if (phase_r == PH_LENGTH && osz_r != 4'd0) begin
              phase_nxt = PH_OFFSET;
              left_nxt  = osz_r;
              pos_nxt   = 3'd0;
            end else begin
              phase_nxt      = PH_HEADER;
              left_nxt       = 4'd0;
              pos_nxt        = 3'd0;
              prev_nxt       = fin_start;
              res.emit       = 1'b1;
              res.kind       = KIND_RUN;
              res.run_length = len_nxt;
              res.run_start  = fin_start;
            end
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (run_byte == 8'd0) begin
            prev_nxt = 64'd0;
            res.emit = 1'b1;
            res.kind = KIND_END;
          end else if (hdr_osz > 4'(MAX_FIELD_BYTES) || hdr_lsz > 4'(MAX_FIELD_BYTES)) begin
            res.emit = 1'b1;
            res.kind = KIND_BAD;
          end else begin
            osz_nxt   = hdr_osz;
            len_nxt   = 64'd0;
            delta_nxt = 64'd0;
            pos_nxt   = 3'd0;
            if (hdr_lsz != 4'd0) begin
              phase_nxt = PH_LENGTH;
              left_nxt  = hdr_lsz;
            end else if (hdr_osz != 4'd0) begin
              phase_nxt = PH_OFFSET;
              left_nxt  = hdr_osz;
            end else begin
              left_nxt      = 4'd0;
              res.emit      = 1'b1;
              res.kind      = KIND_RUN;
              res.run_start = prev_r;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      left_r  <= 4'd0;
      osz_r   <= 4'd0;
      pos_r   <= 3'd0;
      len_r   <= 64'd0;
      delta_r <= 64'd0;
      prev_r  <= 64'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      osz_r   <= osz_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      delta_r <= delta_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

@@ src/data_run_list_decoder.sv @@
// channel  | direction | handshake              | payload
// in_      | input     | in_valid / in_stall    | in_run_byte
// out_     | output    | out_valid / out_stall  | out_kind, out_run_length, out_run_start
//
// one byte per cycle unless out_stall holds; the byte and then its result are registered
// the rate is set by the single decode stage: shift-in, sign extend and one 64-bit add
// reset (rst_n low, synchronous) empties both registers and returns to header phase
// out_stall holds the result register; the input register keeps taking an item
// while the decode stage can drain into it, so no cycle is lost once a stall ends
module data_run_list_decoder import drl_pkg::*; #(
  parameter int MAX_FIELD_BYTES = DRL_MAX_FIELD_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_run_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [63:0]        out_run_length,
  output logic signed [63:0] out_run_start
);

`include "data_run_list_decoder_macros.svh"

  logic       adv;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  res_t       res;
  logic       out_valid_r, out_valid_nxt;
  kind_t      kind_r;
  logic [63:0]        len_r;
  logic signed [63:0] start_r;

  // the decode stage moves whenever the result register is free or draining
  assign adv = !out_valid_r || !out_stall;

  drl_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_run_byte (in_run_byte),
    .adv         (adv),
    .in_stall    (in_stall),
    .valid_r     (in_valid_r),
    .byte_r      (in_byte_r)
  );

  // header parsing, field gathering and the running start all live here
  drl_core #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_valid_r && adv),
    .run_byte (in_byte_r),
    .res      (res)
  );

  // result register: loads only on an item that produces a result
  assign out_valid_nxt = adv ? (in_valid_r && res.emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r && res.emit) begin
      kind_r  <= res.kind;
      len_r   <= res.run_length;
      start_r <= res.run_start;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_run_length = len_r;
  assign out_run_start  = start_r;

  // end markers and bad headers carry no length or start
  `DRL_ASSERT_NOW(a_nonrun_zero, out_valid_r && kind_r != KIND_RUN,
                  len_r == 64'd0 && start_r == 64'sd0)
  // the input side stalls only while it holds an item
  `DRL_ASSERT_NOW(a_stall_holds, in_stall, in_valid_r && out_valid_r && out_stall)
  // an accepted item is in the input register in the following cycle
  `DRL_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, in_valid_r)

endmodule
